### src/esm_pkg.sv
// ----------------------------------------------------------------------------
// esm_pkg
// Shared widths, register indexes, codes and types of the encoder speed meter.
// ----------------------------------------------------------------------------
package esm_pkg;

	// moving-average depth and the widths that follow from it
	localparam int AVG_DEPTH = 8;
	localparam int SLOT_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int SPEED_W   = 20;
	localparam int SUM_W     = SPEED_W + ((AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 0);

	localparam int PULSE_W   = 32;
	localparam int TICK_W    = 16;
	localparam int WINDOW_W  = 16;
	localparam int SCALE_W   = 24;
	localparam int LIMIT_W   = 20;
	localparam int PROD_W    = PULSE_W + SCALE_W;
	localparam int FRAC_DROP = 12;   // q.16 product down to q.4 rpm
	localparam int CFG_DW    = 24;

	localparam logic [SPEED_W-1:0]  SPEED_MAX = '1;
	localparam logic [TICK_W-1:0]   TICK_MAX  = '1;

	localparam logic [WINDOW_W-1:0] WINDOW_RST = WINDOW_W'(100);
	localparam logic [SCALE_W-1:0]  SCALE_RST  = SCALE_W'(1966080);
	localparam logic [LIMIT_W-1:0]  LIMIT_RST  = LIMIT_W'(48000);

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_WINDOW = 2'd0,
		CFG_SCALE  = 2'd1,
		CFG_LIMIT  = 2'd2
	} cfg_idx_t;

	// item kinds
	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// direction codes
	localparam logic signed [1:0] DIR_STOP = 2'sb00;
	localparam logic signed [1:0] DIR_FWD  = 2'sb01;
	localparam logic signed [1:0] DIR_REV  = 2'sb11;

	// new speed sample pushed into the averaging ring
	typedef struct packed {
		logic               push;
		logic [SPEED_W-1:0] speed;
	} push_t;

endpackage

### src/esm_if.sv
// ----------------------------------------------------------------------------
// esm_if
// Valid/ready channels of the encoder speed meter: item in, result out.
// ----------------------------------------------------------------------------
interface esm_in_if;
	logic valid;
	logic ready;
	logic operation;
	logic b_level;

	modport source (output valid, output operation, output b_level, input ready);
	modport sink   (input valid, input operation, input b_level, output ready);
endinterface

interface esm_out_if;
	logic                             valid;
	logic                             ready;
	logic                             sample_taken;
	logic [esm_pkg::SPEED_W-1:0]      speed_rpm;
	logic [esm_pkg::SPEED_W-1:0]      speed_filtered;
	logic signed [1:0]                direction;
	logic                             overspeed;

	modport source (output valid, output sample_taken, output speed_rpm,
		output speed_filtered, output direction, output overspeed, input ready);
	modport sink   (input valid, input sample_taken, input speed_rpm,
		input speed_filtered, input direction, input overspeed, output ready);
endinterface

### src/esm_ring.sv
// ----------------------------------------------------------------------------
// esm_ring
// Moving-average ring with a running sum; gives the average after a push.
// ----------------------------------------------------------------------------
module esm_ring (
	input  logic                        clk,
	input  logic                        arst_n,
	input  esm_pkg::push_t              push,
	output logic [esm_pkg::SPEED_W-1:0] filtered_next
);

	logic [esm_pkg::SPEED_W-1:0] hist_q [esm_pkg::AVG_DEPTH];
	logic [esm_pkg::SLOT_W-1:0]  slot_q;
	logic [esm_pkg::SUM_W-1:0]   sum_q;
	logic [esm_pkg::SUM_W-1:0]   sum_next;
	logic [esm_pkg::SLOT_W-1:0]  slot_next;

	assign sum_next = sum_q - esm_pkg::SUM_W'(hist_q[slot_q])
		+ esm_pkg::SUM_W'(push.speed);
	assign slot_next = (slot_q == esm_pkg::SLOT_W'(esm_pkg::AVG_DEPTH - 1)) ?
		'0 : slot_q + esm_pkg::SLOT_W'(1);

	always_comb begin
		if (push.push) begin
			filtered_next = esm_pkg::SPEED_W'(sum_next / esm_pkg::AVG_DEPTH);
		end else begin
			filtered_next = esm_pkg::SPEED_W'(sum_q / esm_pkg::AVG_DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < esm_pkg::AVG_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			slot_q <= '0;
			sum_q  <= '0;
		end else if (push.push) begin
			hist_q[slot_q] <= push.speed;
			slot_q         <= slot_next;
			sum_q          <= sum_next;
		end
	end

endmodule

### src/encoder_speed_meter_core.sv
// ----------------------------------------------------------------------------
// encoder_speed_meter_core
// Encoder pulse counter with tick-driven speed sampling and moving average.
// ----------------------------------------------------------------------------
//  channel | dir | transfer carries
//  --------+-----+--------------------------------------------------------
//  in      | in  | operation (edge or tick), b_level
//  out     | out | sample_taken, speed_rpm, speed_filtered, direction,
//          |     | overspeed
//  cfg_*   | in  | plain write: window length, rpm scale, overspeed threshold
//
//  one item per cycle sustained while the output is not stalled; a result is
//  registered in the stage 1 register, then in the output register
//  stage 1: pulse count, window count, delta and the one 32x24 multiply
//  stage 2: saturation, averaging ring update, output register
//  reset clears counts, ring, valid flags and output, and sets config defaults
//  an output stall holds the output register and backs pressure up one stage
// ----------------------------------------------------------------------------
module encoder_speed_meter_core (
	input  logic                        clk,
	input  logic                        arst_n,
	esm_in_if.sink                      in,
	esm_out_if.source                   out,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [esm_pkg::CFG_DW-1:0]  cfg_data
);

	// configuration registers
	logic [esm_pkg::WINDOW_W-1:0] window_q;
	logic [esm_pkg::SCALE_W-1:0]  scale_q;
	logic [esm_pkg::LIMIT_W-1:0]  limit_q;

	// counting state, owned by stage 1
	logic [esm_pkg::PULSE_W-1:0]  pulse_total_q;
	logic [esm_pkg::PULSE_W-1:0]  pulse_last_q;
	logic [esm_pkg::TICK_W-1:0]   ticks_q;

	// stage 1 pipeline register
	logic                         valid_s1;
	logic                         sample_s1;
	logic signed [1:0]            dir_s1;
	logic [esm_pkg::PROD_W-1:0]   product_s1;

	// output register, which also holds last speed and direction
	logic                         out_valid_q;
	logic                         out_sample_q;
	logic [esm_pkg::SPEED_W-1:0]  out_speed_q;
	logic [esm_pkg::SPEED_W-1:0]  out_filt_q;
	logic signed [1:0]            out_dir_q;

	logic                         accept;
	logic                         advance;
	logic                         move;
	logic [esm_pkg::TICK_W-1:0]   ticks_inc;
	logic                         take;
	logic [esm_pkg::PULSE_W-1:0]  diff;
	logic [esm_pkg::PULSE_W-1:0]  mag;
	logic signed [1:0]            dir_new;
	logic [esm_pkg::SPEED_W-1:0]  speed_sat;
	logic [esm_pkg::SPEED_W-1:0]  filtered_next;
	esm_pkg::push_t               push;

	// ---------------- configuration writes ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= esm_pkg::WINDOW_RST;
			scale_q  <= esm_pkg::SCALE_RST;
			limit_q  <= esm_pkg::LIMIT_RST;
		end else if (cfg_we) begin
			unique case (esm_pkg::cfg_idx_t'(cfg_index))
				esm_pkg::CFG_WINDOW: window_q <= cfg_data[esm_pkg::WINDOW_W-1:0];
				esm_pkg::CFG_SCALE:  scale_q  <= cfg_data[esm_pkg::SCALE_W-1:0];
				esm_pkg::CFG_LIMIT:  limit_q  <= cfg_data[esm_pkg::LIMIT_W-1:0];
				default: ;   // unused index, write dropped
			endcase
		end
	end

	// ---------------- handshake ----------------
	// whole pipe advances when the output register is free or being emptied
	assign advance  = !out_valid_q || out.ready;
	assign move     = valid_s1 && advance;
	assign in.ready = !valid_s1 || advance;
	assign accept   = in.valid && in.ready;

	// ---------------- stage 1: counting and scaling ----------------
	// tick counter saturates so it can never wrap past a long window
	assign ticks_inc = (ticks_q == esm_pkg::TICK_MAX) ? ticks_q :
		ticks_q + esm_pkg::TICK_W'(1);
	assign take = (in.operation == esm_pkg::OP_TICK) && (ticks_inc >= window_q);

	// signed delta since the last sample, mod 2^32
	assign diff = pulse_total_q - pulse_last_q;
	assign mag  = diff[esm_pkg::PULSE_W-1] ? (~diff + esm_pkg::PULSE_W'(1)) : diff;

	always_comb begin
		if (diff == '0) begin
			dir_new = esm_pkg::DIR_STOP;
		end else if (diff[esm_pkg::PULSE_W-1]) begin
			dir_new = esm_pkg::DIR_REV;
		end else begin
			dir_new = esm_pkg::DIR_FWD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_total_q <= '0;
			pulse_last_q  <= '0;
			ticks_q       <= '0;
		end else if (accept) begin
			if (in.operation == esm_pkg::OP_EDGE) begin
				// channel b high counts forward, low counts back
				pulse_total_q <= in.b_level ? pulse_total_q + esm_pkg::PULSE_W'(1) :
					pulse_total_q - esm_pkg::PULSE_W'(1);
			end else if (take) begin
				ticks_q      <= '0;
				pulse_last_q <= pulse_total_q;
			end else begin
				ticks_q <= ticks_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in.ready) begin
			valid_s1 <= accept;
		end
	end

	// payload of stage 1, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1  <= take;
			dir_s1     <= dir_new;
			product_s1 <= esm_pkg::PROD_W'(mag) * esm_pkg::PROD_W'(scale_q);
		end
	end

	// ---------------- stage 2: saturation and averaging ----------------
	// q.16 to q.4, clamp anything above the 20-bit range
	always_comb begin
		if (|product_s1[esm_pkg::PROD_W-1:esm_pkg::FRAC_DROP+esm_pkg::SPEED_W]) begin
			speed_sat = esm_pkg::SPEED_MAX;
		end else begin
			speed_sat = product_s1[esm_pkg::FRAC_DROP+esm_pkg::SPEED_W-1:esm_pkg::FRAC_DROP];
		end
	end

	assign push.push  = move && sample_s1;
	assign push.speed = speed_sat;

	esm_ring u_ring (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.filtered_next (filtered_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_sample_q <= 1'b0;
			out_speed_q  <= '0;
			out_filt_q   <= '0;
			out_dir_q    <= esm_pkg::DIR_STOP;
		end else if (move) begin
			out_valid_q  <= 1'b1;
			out_sample_q <= sample_s1;
			out_filt_q   <= filtered_next;
			if (sample_s1) begin
				out_speed_q <= speed_sat;
				out_dir_q   <= dir_s1;
			end
		end else if (advance) begin
			out_valid_q <= 1'b0;
		end
	end

	// ---------------- result channel ----------------
	assign out.valid          = out_valid_q;
	assign out.sample_taken   = out_sample_q;
	assign out.speed_rpm      = out_speed_q;
	assign out.speed_filtered = out_filt_q;
	assign out.direction      = out_dir_q;
	// limit compared live, against whatever is currently programmed
	assign out.overspeed      = (out_filt_q > limit_q);

endmodule

### src/esm_checker.sv
// ----------------------------------------------------------------------------
// esm_checker
// Port-level checks on the encoder speed meter, bound to the top level.
// ----------------------------------------------------------------------------
module esm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        sample_taken,
	input logic [esm_pkg::SPEED_W-1:0] speed_rpm,
	input logic [esm_pkg::SPEED_W-1:0] speed_filtered,
	input logic signed [1:0]           direction
);

	// stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(speed_rpm)
			&& $stable(speed_filtered) && $stable(direction))
		else $error("result changed while stalled");

	// direction is only stopped, forward or reverse
	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (direction == esm_pkg::DIR_STOP) || (direction == esm_pkg::DIR_FWD)
			|| (direction == esm_pkg::DIR_REV))
		else $error("bad direction code");

	// no pulses in a window means zero speed
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample_taken && (direction == esm_pkg::DIR_STOP) |-> speed_rpm == '0)
		else $error("stopped sample with nonzero speed");

	// an empty output register never blocks the input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with no result pending");

	// nothing shown straight after reset
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result valid after reset");

endmodule

bind encoder_speed_meter_core esm_checker u_esm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (in.ready),
	.out_valid      (out.valid),
	.out_ready      (out.ready),
	.sample_taken   (out.sample_taken),
	.speed_rpm      (out.speed_rpm),
	.speed_filtered (out.speed_filtered),
	.direction      (out.direction)
);

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the encoder speed meter core. Channel-A edges and
// millisecond ticks are pushed through the item channel with random gaps, and
// every result is compared with a cycle-free model of the meter kept here.
// ----------------------------------------------------------------------------
module tb_top;
	import esm_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD      = 80;

	// one encoder event as offered on the item channel
	typedef struct packed {
		logic op;
		logic b;
	} encoder_event_t;

	// one meter reading as expected on the result channel
	typedef struct {
		logic               sample_taken;
		logic [SPEED_W-1:0] speed_rpm;
		logic [SPEED_W-1:0] speed_filtered;
		logic signed [1:0]  direction;
		logic               overspeed;
	} meter_reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// configuration write port
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = CFG_WINDOW;
	logic [CFG_DW-1:0] cfg_data = '0;

	// driven sides of the two channels
	logic drv_valid = 1'b0;
	logic drv_op = OP_EDGE;
	logic drv_b = 1'b0;
	logic rdy = 1'b0;

	esm_in_if  in_ch ();
	esm_out_if out_ch ();

	assign in_ch.valid     = drv_valid;
	assign in_ch.operation = drv_op;
	assign in_ch.b_level   = drv_b;
	assign out_ch.ready    = rdy;

	encoder_speed_meter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (in_ch),
		.out       (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// events waiting to be offered, readings waiting to come back
	encoder_event_t encoder_events [$];
	meter_reading_t pending_readings [$];

	// idle percentages of sender and receiver
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	int error_count = 0;
	int events_accepted = 0;
	int results_seen = 0;
	int windows_closed = 0;
	int hold_left = 0;
	bit long_hold_done = 1'b0;
	int idle_cycles = 0;

	// model copy of the configuration registers
	logic [WINDOW_W-1:0] win_len = WINDOW_RST;
	logic [SCALE_W-1:0]  rpm_mult = SCALE_RST;
	logic [LIMIT_W-1:0]  over_limit = LIMIT_RST;

	// model copy of the meter state
	logic [PULSE_W-1:0] pulse_count = '0;
	logic [PULSE_W-1:0] pulse_mark = '0;
	logic [TICK_W-1:0]  tick_count = '0;
	logic [SPEED_W-1:0] speed_ring [AVG_DEPTH] = '{default: '0};
	logic [SLOT_W-1:0]  ring_slot = '0;
	logic [SUM_W-1:0]   ring_sum = '0;
	logic [SPEED_W-1:0] speed_now = '0;
	logic [SPEED_W-1:0] speed_avg = '0;
	logic signed [1:0]  dir_now = DIR_STOP;

	// ------------------------------------------------------------------------
	// meter model: one accepted event in, one expected reading queued
	// ------------------------------------------------------------------------
	function automatic void advance_meter(input logic op, input logic b);
		logic [PULSE_W-1:0] delta;
		logic [PULSE_W-1:0] mag;
		logic [PROD_W-1:0]  prod;
		meter_reading_t     rd;
		rd.sample_taken = 1'b0;
		if (op == OP_EDGE) begin
			// b high counts up, b low counts down, both wrap at 32 bits
			pulse_count = b ? pulse_count + 1'b1 : pulse_count - 1'b1;
		end else begin
			// b is ignored on a tick; the counter saturates
			if (tick_count != TICK_MAX)
				tick_count = tick_count + 1'b1;
			// a zero window closes on every tick
			if (tick_count >= win_len) begin
				rd.sample_taken = 1'b1;
				delta = pulse_count - pulse_mark;
				pulse_mark = pulse_count;
				tick_count = '0;
				if (delta == '0) begin
					dir_now = DIR_STOP;
					mag = '0;
				end else if (!delta[PULSE_W-1]) begin
					dir_now = DIR_FWD;
					mag = delta;
				end else begin
					dir_now = DIR_REV;
					mag = ~delta + 1'b1;
				end
				// q.16 product down to q.4, saturated to the speed width
				prod = (PROD_W'(mag) * PROD_W'(rpm_mult)) >> FRAC_DROP;
				speed_now = (prod > PROD_W'(SPEED_MAX)) ? SPEED_MAX : prod[SPEED_W-1:0];
				// running sum over the ring
				ring_sum = ring_sum - SUM_W'(speed_ring[ring_slot]) + SUM_W'(speed_now);
				speed_ring[ring_slot] = speed_now;
				ring_slot = (ring_slot == SLOT_W'(AVG_DEPTH - 1)) ? '0 : ring_slot + 1'b1;
				speed_avg = SPEED_W'(ring_sum / AVG_DEPTH);
			end
		end
		rd.speed_rpm = speed_now;
		rd.speed_filtered = speed_avg;
		rd.direction = dir_now;
		// overspeed against the limit in force now
		rd.overspeed = (speed_avg > over_limit);
		pending_readings.push_back(rd);
	endfunction

	function automatic void check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			error_count++;
		end
	endfunction

	// ------------------------------------------------------------------------
	// driver: offers queued events, holds an offer until its transfer
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : event_driver
		encoder_event_t nxt;
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_op <= OP_EDGE;
			drv_b <= 1'b0;
		end else begin
			if (drv_valid && in_ch.ready) begin
				advance_meter(drv_op, drv_b);
				events_accepted++;
			end
			if (!drv_valid || in_ch.ready) begin
				if (encoder_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = encoder_events.pop_front();
					drv_valid <= 1'b1;
					drv_op <= nxt.op;
					drv_b <= nxt.b;
				end else begin
					// idle: payload wiggles while valid is low
					drv_valid <= 1'b0;
					drv_op <= 1'($urandom_range(1));
					drv_b <= 1'($urandom_range(1));
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: checks each result transfer against the oldest expectation
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : reading_monitor
		meter_reading_t want;
		if (!arst_n) begin
			rdy <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (pending_readings.size() == 0) begin
					$error("result transfer with no expected reading waiting");
					error_count++;
				end else begin
					want = pending_readings.pop_front();
					if (want.sample_taken)
						windows_closed++;
					check_field("sample_taken", 32'(want.sample_taken), 32'(out_ch.sample_taken));
					check_field("speed_rpm", 32'(want.speed_rpm), 32'(out_ch.speed_rpm));
					check_field("speed_filtered", 32'(want.speed_filtered),
						32'(out_ch.speed_filtered));
					check_field("direction", 32'(unsigned'(want.direction)),
						32'(unsigned'(out_ch.direction)));
					check_field("overspeed", 32'(want.overspeed), 32'(out_ch.overspeed));
				end
			end
			// one long hold-off while plenty of events are still queued,
			// so the pipeline fills and the input side stalls
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				rdy <= 1'b0;
			end else if (!long_hold_done && results_seen >= 100 && encoder_events.size() > 40) begin
				long_hold_done <= 1'b1;
				hold_left <= LONG_HOLD;
				rdy <= 1'b0;
			end else begin
				rdy <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog: cycles without any transfer on either channel
	always @(posedge clk) begin
		if ((drv_valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", idle_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	// register write while idle; bits above the register width are junk
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] val);
		logic [CFG_DW-1:0] word;
		word = CFG_DW'($urandom());
		case (idx)
			CFG_WINDOW: begin
				word[WINDOW_W-1:0] = val[WINDOW_W-1:0];
				win_len = val[WINDOW_W-1:0];
			end
			CFG_SCALE: begin
				word[SCALE_W-1:0] = val[SCALE_W-1:0];
				rpm_mult = val[SCALE_W-1:0];
			end
			default: begin
				word[LIMIT_W-1:0] = val[LIMIT_W-1:0];
				over_limit = val[LIMIT_W-1:0];
			end
		endcase
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= word;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// waits until every queued event is sent and every expected reading is back, then a short pause
	task automatic drain;
		while (encoder_events.size() != 0 || pending_readings.size() != 0 || drv_valid)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// edges in one direction mode, then ticks
	// mode 0 forward, 1 reverse, otherwise mixed
	task automatic queue_window(input int edges, input int mode, input int ticks);
		encoder_event_t ev;
		repeat (edges) begin
			ev.op = OP_EDGE;
			ev.b = (mode == 0) ? 1'b1 : (mode == 1) ? 1'b0 : 1'($urandom_range(1));
			encoder_events.push_back(ev);
		end
		repeat (ticks) begin
			ev.op = OP_TICK;
			ev.b = 1'($urandom_range(1));
			encoder_events.push_back(ev);
		end
	endtask

	task automatic run_phase(input logic [WINDOW_W-1:0] win, input logic [SCALE_W-1:0] scale,
			input logic [LIMIT_W-1:0] limit, input int s_pct, input int r_pct,
			input int count, input int bursts);
		encoder_event_t ev;
		int ticks;
		write_reg(CFG_WINDOW, CFG_DW'(win));
		write_reg(CFG_SCALE, CFG_DW'(scale));
		write_reg(CFG_LIMIT, CFG_DW'(limit));
		@(posedge clk);
		send_idle_pct <= s_pct;
		recv_idle_pct <= r_pct;
		// ticks that close a window in most cases
		ticks = (win == 0) ? 1 : (win <= 8) ? int'(win) : 8;
		// long runs of edges push the speed into saturation
		repeat (bursts)
			queue_window($urandom_range(257, 300), $urandom_range(1), ticks);
		while (encoder_events.size() < count) begin
			if ($urandom_range(99) < 80) begin
				queue_window($urandom_range(12), $urandom_range(2),
					$urandom_range(ticks, ticks + 1));
			end else begin
				repeat ($urandom_range(1, 6)) begin
					ev.op = 1'($urandom_range(1));
					ev.b = 1'($urandom_range(1));
					encoder_events.push_back(ev);
				end
			end
		end
		drain();
	endtask

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: edges both ways, ticks with random b, no window closes
		queue_window(1, 0, 0);
		queue_window(1, 1, 0);
		queue_window(0, 0, 2);
		drain();

		// one-tick window, limit zero: forward, stopped, reverse, net zero,
		// then a count that wraps below zero
		write_reg(CFG_WINDOW, CFG_DW'(1));
		write_reg(CFG_LIMIT, CFG_DW'(0));
		queue_window(3, 0, 1);
		queue_window(0, 0, 1);
		queue_window(2, 1, 1);
		queue_window(1, 1, 0);
		queue_window(1, 0, 1);
		queue_window(3, 1, 1);
		drain();

		// receiver idles most, sender rarely
		run_phase(WINDOW_W'(1), SCALE_RST, LIMIT_W'(0), 9, 60, 150, 0);
		run_phase(WINDOW_W'(3), '1, '1, 9, 60, 600, 2);
		// sender idles most, receiver rarely; zero window and zero scale
		run_phase(WINDOW_W'(0), '0, '0, 60, 9, 120, 0);
		run_phase(WINDOW_W'(5), SCALE_W'($urandom()), LIMIT_W'($urandom_range(50000)),
			60, 9, 150, 0);
		// no idling on either side
		run_phase(WINDOW_W'(2), SCALE_RST, LIMIT_W'(2000), 0, 0, 150, 0);
		run_phase('1, SCALE_W'(1), LIMIT_RST, 0, 0, 80, 0);

		if (pending_readings.size() != 0) begin
			$error("%0d expected readings never arrived", pending_readings.size());
			error_count++;
		end

		$display("covered %0d encoder events and %0d readings, %0d of them closing a window",
			events_accepted, results_seen, windows_closed);
		$display("window lengths 0 to 65535, rpm scale 0 to full, limits 0 to full, %0d errors",
			error_count);
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

### sim.f
src/esm_pkg.sv
src/esm_if.sv
src/esm_ring.sv
src/encoder_speed_meter_core.sv
src/esm_checker.sv
tb/tb_top.sv
